// File: sv/tael_pkg.sv
// ---------------------------------------------------------------------------
// tael_pkg
// Types and codes shared by the threshold alarm event logger.
// ---------------------------------------------------------------------------
package tael_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_REARM  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ALARM = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ACK   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_LIMIT0 = 2'd0,
        REG_LIMIT1 = 2'd1,
        REG_LIMIT2 = 2'd2,
        REG_REPORT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    localparam int unsigned NUM_CHAN    = 3;
    localparam logic [1:0]  LAST_CHAN   = 2'd2;
    localparam logic [31:0] LIMIT0_INIT = 32'd768000;
    localparam logic [31:0] LIMIT1_INIT = 32'd768000;
    localparam logic [31:0] LIMIT2_INIT = 32'd20480;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         chan;
        logic signed [31:0] sample_value;
        logic [31:0]        stamp_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        rec_stamp;
        logic [1:0]         rec_chan;
        logic signed [31:0] rec_limit;
        logic signed [31:0] rec_value;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        stamp;
        logic [1:0]         chan;
        logic signed [31:0] limit;
        logic signed [31:0] value;
    } log_rec_t;

endpackage

// File: sv/threshold_alarm_event_logger.sv
// ---------------------------------------------------------------------------
// threshold_alarm_event_logger
// Three-channel threshold alarm with a ring log of alarm records.
// ---------------------------------------------------------------------------
// Clear, rearm and newly alarming sample items (with reporting on) give a
// result on m_ the cycle after acceptance. A non-empty query reads the log:
// each record passes the read register and the output register, one record
// per cycle while m_ready stays high (one memory read port). The next item is
// accepted once the last result is in the output register and being taken.
// Reset clears control state, flags and count, and loads the threshold reset
// values; log memory contents stay undefined and need no clearing pass.
module threshold_alarm_event_logger
    import tael_pkg::*;
#(
    parameter int unsigned LOG_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    // Configuration registers
    logic [31:0] limit0_reg, limit1_reg, limit2_reg;
    logic        report_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit0_reg <= LIMIT0_INIT;
            limit1_reg <= LIMIT1_INIT;
            limit2_reg <= LIMIT2_INIT;
            report_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LIMIT0: limit0_reg <= pwdata;
                REG_LIMIT1: limit1_reg <= pwdata;
                REG_LIMIT2: limit2_reg <= pwdata;
                REG_REPORT: report_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LIMIT0: prdata = limit0_reg;
            REG_LIMIT1: prdata = limit1_reg;
            REG_LIMIT2: prdata = limit2_reg;
            REG_REPORT: prdata = {31'd0, report_reg};
            default:    prdata = '0;
        endcase
    end

    // Log memory: one write port, one registered read port
    log_rec_t        log_mem [LOG_DEPTH];
    log_rec_t        mem_rd_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    log_rec_t        mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            log_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_rd_reg <= log_mem[mem_raddr];
        end
    end

    // Control state
    state_t                state_reg, state_next;
    logic [NUM_CHAN-1:0]   flags_reg, flags_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         wslot_reg, wslot_next;
    logic [AW-1:0]         rptr_reg, rptr_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    logic        out_free;
    logic        in_acc;
    logic [31:0] sel_limit;
    logic        over;

    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_item_reg;

    always_comb begin
        case (s_data.chan)
            2'd0:    sel_limit = limit0_reg;
            2'd1:    sel_limit = limit1_reg;
            default: sel_limit = limit2_reg;
        endcase
    end

    assign over = s_data.sample_value > $signed(sel_limit);

    always_comb begin
        state_next   = state_reg;
        flags_next   = flags_reg;
        count_next   = count_reg;
        wslot_next   = wslot_reg;
        rptr_next    = rptr_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_item_next  = m_item_reg;
        mem_we       = 1'b0;
        mem_waddr    = wslot_reg;
        mem_wdata    = '{stamp: s_data.stamp_seconds, chan: s_data.chan,
                         limit: sel_limit, value: s_data.sample_value};
        mem_re       = 1'b0;
        mem_raddr    = rptr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (action_t'(s_data.action))
                        ACT_SAMPLE: begin
                            // Channel 3 is ignored
                            if (s_data.chan <= LAST_CHAN) begin
                                flags_next[s_data.chan] = over;
                                if (over && !flags_reg[s_data.chan]) begin
                                    mem_we     = 1'b1;
                                    wslot_next = slot_next(wslot_reg);
                                    if (count_reg < FULL_COUNT) begin
                                        count_next = count_reg + CW'(1);
                                    end
                                    if (report_reg) begin
                                        m_valid_next = 1'b1;
                                        m_item_next  = '{kind: KIND_ALARM,
                                            rec_stamp: s_data.stamp_seconds,
                                            rec_chan: s_data.chan,
                                            rec_limit: sel_limit,
                                            rec_value: s_data.sample_value,
                                            last: 1'b1};
                                    end
                                end
                            end
                        end
                        ACT_QUERY: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_item_next  = '{kind: KIND_EMPTY, rec_stamp: '0,
                                    rec_chan: '0, rec_limit: '0, rec_value: '0,
                                    last: 1'b1};
                            end else begin
                                // Fetch the newest record, then walk backward
                                mem_re      = 1'b1;
                                mem_raddr   = slot_prev(wslot_reg);
                                rptr_next   = slot_prev(slot_prev(wslot_reg));
                                remain_next = count_reg;
                                state_next  = ST_EMIT;
                            end
                        end
                        ACT_CLEAR: begin
                            count_next   = '0;
                            wslot_next   = '0;
                            flags_next   = '1;
                            m_valid_next = 1'b1;
                            m_item_next  = '{kind: KIND_ACK, rec_stamp: '0,
                                rec_chan: '0, rec_limit: '0, rec_value: '0,
                                last: 1'b1};
                        end
                        default: begin
                            flags_next   = '0;
                            m_valid_next = 1'b1;
                            m_item_next  = '{kind: KIND_ACK, rec_stamp: '0,
                                rec_chan: '0, rec_limit: '0, rec_value: '0,
                                last: 1'b1};
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                // Hold the read data until the output register can take it
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{kind: KIND_ALARM, rec_stamp: mem_rd_reg.stamp,
                        rec_chan: mem_rd_reg.chan, rec_limit: mem_rd_reg.limit,
                        rec_value: mem_rd_reg.value, last: (remain_reg == CW'(1))};
                    remain_next  = remain_reg - CW'(1);
                    if (remain_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = rptr_reg;
                        rptr_next = slot_prev(rptr_reg);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flags_reg   <= '0;
            count_reg   <= '0;
            wslot_reg   <= '0;
            rptr_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            count_reg   <= count_next;
            wslot_reg   <= wslot_next;
            rptr_reg    <= rptr_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives sample, query, clear and rearm items into the alarm logger under
// random source gaps and sink stalls, tracks thresholds, over flags and the
// ring log alongside the block, and checks every result in order.
// ---------------------------------------------------------------------------
module testbench;
    import tael_pkg::*;

    localparam int RING_DEPTH     = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 68;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // thresholds and report switch as last written
    logic signed [31:0] chan_limit [NUM_CHAN];
    bit                 report_on;

    // alarm state tracked alongside the block
    bit         over_flag [NUM_CHAN];
    log_rec_t   ring [RING_DEPTH];
    int         ring_count;
    int         ring_next;

    in_item_t   pending [$];
    out_item_t  results_due [$];
    int         mismatch_count;
    int         stray_cycles;

    int src_wait, src_stretch;
    bit src_calm;
    int sink_wait, sink_stretch;
    bit sink_calm;

    threshold_alarm_event_logger u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    function automatic out_item_t pack_result(kind_t k, log_rec_t rec, logic fin);
        out_item_t r;
        r.kind      = k;
        r.rec_stamp = rec.stamp;
        r.rec_chan  = rec.chan;
        r.rec_limit = rec.limit;
        r.rec_value = rec.value;
        r.last      = fin;
        return r;
    endfunction

    task automatic forecast_results(in_item_t it);
        logic signed [31:0] lim;
        log_rec_t           rec;
        bit                 over;
        int                 idx;
        case (it.action)
            ACT_SAMPLE: begin
                // channel 3 is ignored outright
                if (it.chan <= LAST_CHAN) begin
                    lim  = chan_limit[it.chan];
                    over = ($signed(it.sample_value) > $signed(lim));
                    if (over && !over_flag[it.chan]) begin
                        rec.stamp = it.stamp_seconds;
                        rec.chan  = it.chan;
                        rec.limit = lim;
                        rec.value = it.sample_value;
                        ring[ring_next] = rec;
                        ring_next = (ring_next == RING_DEPTH - 1) ? 0 : ring_next + 1;
                        if (ring_count < RING_DEPTH) ring_count++;
                        if (report_on)
                            results_due.push_back(pack_result(KIND_ALARM, rec, 1'b1));
                    end
                    over_flag[it.chan] = over;
                end
            end
            ACT_QUERY: begin
                if (ring_count == 0) begin
                    results_due.push_back(pack_result(KIND_EMPTY, '0, 1'b1));
                end else begin
                    // walk newest first
                    for (int i = 0; i < ring_count; i++) begin
                        idx = (ring_next + 2 * RING_DEPTH - 1 - i) % RING_DEPTH;
                        results_due.push_back(pack_result(KIND_ALARM, ring[idx],
                                                          i == ring_count - 1));
                    end
                end
            end
            ACT_CLEAR: begin
                ring_count = 0;
                ring_next  = 0;
                for (int c = 0; c < NUM_CHAN; c++) over_flag[c] = 1'b1;
                results_due.push_back(pack_result(KIND_ACK, '0, 1'b1));
            end
            ACT_REARM: begin
                for (int c = 0; c < NUM_CHAN; c++) over_flag[c] = 1'b0;
                results_due.push_back(pack_result(KIND_ACK, '0, 1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        bit        bad;
        if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display({"%0t: result with none pending: kind %0d stamp %h chan %0d",
                          " limit %h value %h last %0b"},
                         $realtime, got.kind, got.rec_stamp, got.rec_chan, got.rec_limit,
                         got.rec_value, got.last);
            return;
        end
        want = results_due.pop_front();
        bad = (got.kind !== want.kind) || (got.rec_stamp !== want.rec_stamp)
            || (got.rec_chan !== want.rec_chan) || (got.rec_limit !== want.rec_limit)
            || (got.rec_value !== want.rec_value) || (got.last !== want.last);
        if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: mismatch", $realtime);
                $display("  expected kind %0d stamp %h chan %0d limit %h value %h last %0b",
                         want.kind, want.rec_stamp, want.rec_chan, want.rec_limit,
                         want.rec_value, want.last);
                $display("  actual   kind %0d stamp %h chan %0d limit %h value %h last %0b",
                         got.kind, got.rec_stamp, got.rec_chan, got.rec_limit,
                         got.rec_value, got.last);
            end
        end
    endtask

    // source side: hold each item until taken, then idle for the drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_valid && s_ready) forecast_results(s_data);
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    s_valid <= 1'b0;
                    src_wait--;
                end else if (pending.size() != 0) begin
                    s_data  <= pending.pop_front();
                    s_valid <= 1'b1;
                    if (src_stretch == 0) begin
                        src_stretch = $urandom_range(8, 40);
                        src_calm    = ($urandom_range(0, 3) == 0);
                    end
                    src_stretch--;
                    src_wait = src_calm ? 0 : $urandom_range(0, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: check each result, then stall for the drawn count
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                if (sink_stretch == 0) begin
                    sink_stretch = $urandom_range(8, 40);
                    sink_calm    = ($urandom_range(0, 3) == 0);
                end
                sink_stretch--;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 6);
            end
            if (sink_wait > 0) begin
                m_ready <= 1'b0;
                sink_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (psel && penable && pready)) begin
            stray_cycles <= 0;
        end else if (stray_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stray_cycles <= stray_cycles + 1;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LIMIT0: chan_limit[0] = val;
            REG_LIMIT1: chan_limit[1] = val;
            REG_LIMIT2: chan_limit[2] = val;
            REG_REPORT: report_on = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_until_idle();
        do @(negedge aclk); while (pending.size() != 0 || s_valid || results_due.size() != 0);
        // a sample with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic in_item_t mk_item(action_t act, logic [1:0] ch, logic [31:0] val,
                                         logic [31:0] stamp);
        in_item_t it;
        it.action        = act;
        it.chan          = ch;
        it.sample_value  = val;
        it.stamp_seconds = stamp;
        return it;
    endfunction

    // value just at/below or just above a threshold, random where that would wrap
    function automatic logic [31:0] near_limit(logic signed [31:0] lim, bit go_above);
        longint v;
        v = longint'(lim) + (go_above ? longint'($urandom_range(1, 4096))
                                      : 1 - longint'($urandom_range(1, 4096)));
        if (v > 64'sd2147483647 || v < -64'sd2147483648) return $urandom;
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            3: return $urandom_range(0, 2000) - 1000;
            default: return $urandom_range(20480, 768000);
        endcase
    endfunction

    initial begin
        int pick, ch;
        chan_limit[0] = LIMIT0_INIT;
        chan_limit[1] = LIMIT1_INIT;
        chan_limit[2] = LIMIT2_INIT;
        report_on      = 1'b0;
        for (int c = 0; c < NUM_CHAN; c++) over_flag[c] = 1'b0;
        ring_count     = 0;
        ring_next      = 0;
        mismatch_count = 0;
        stray_cycles   = 0;
        src_stretch    = 0;
        sink_stretch   = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset thresholds, reporting off
        pending.push_back(mk_item(ACT_QUERY, 2'd0, 32'd0, 32'd0));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'd768000, 32'd10));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'd768001, 32'd11));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'h7FFF_FFFF, 32'd12));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'h8000_0000, 32'd13));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'd768001, 32'd14));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd3, 32'h7FFF_FFFF, 32'd15));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd2, 32'd20481, 32'd16));
        pending.push_back(mk_item(ACT_QUERY, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(mk_item(ACT_CLEAR, 2'd0, 32'd0, 32'd0));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd2, 32'h7FFF_FFFF, 32'd17));
        pending.push_back(mk_item(ACT_QUERY, 2'd0, 32'd0, 32'd0));
        pending.push_back(mk_item(ACT_REARM, 2'd0, 32'd0, 32'd0));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd2, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd1, 32'd768001, 32'd0));
        wait_until_idle();

        // extreme thresholds, reporting on
        reg_write(REG_LIMIT0, 32'h7FFF_FFFF);
        reg_write(REG_LIMIT1, 32'h8000_0000);
        reg_write(REG_LIMIT2, 32'hFFFF_FFFF);
        reg_write(REG_REPORT, 32'd1);
        pending.push_back(mk_item(ACT_REARM, 2'd0, 32'd0, 32'd0));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd1, 32'h8000_0000, 32'd20));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd1, 32'h8000_0001, 32'd21));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd0, 32'h7FFF_FFFF, 32'd22));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd2, 32'hFFFF_FFFF, 32'd23));
        pending.push_back(mk_item(ACT_SAMPLE, 2'd2, 32'd0, 32'd24));
        pending.push_back(mk_item(ACT_QUERY, 2'd0, 32'd0, 32'd0));
        wait_until_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            reg_write(REG_LIMIT0, pick_limit());
            reg_write(REG_LIMIT1, pick_limit());
            reg_write(REG_LIMIT2, pick_limit());
            reg_write(REG_REPORT, 32'(ph % 2));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                ch   = $urandom_range(0, 2);
                // mostly crossings around the threshold, the rest noise
                if (pick < 62)
                    pending.push_back(mk_item(ACT_SAMPLE, 2'(ch),
                                              near_limit(chan_limit[ch],
                                                         1'($urandom_range(0, 1))),
                                              $urandom));
                else if (pick < 72)
                    pending.push_back(mk_item(ACT_SAMPLE, 2'($urandom_range(0, 3)),
                                              $urandom, $urandom));
                else if (pick < 88)
                    pending.push_back(mk_item(ACT_QUERY, 2'($urandom_range(0, 3)),
                                              $urandom, $urandom));
                else if (pick < 93)
                    pending.push_back(mk_item(ACT_CLEAR, 2'($urandom_range(0, 3)),
                                              $urandom, $urandom));
                else
                    pending.push_back(mk_item(ACT_REARM, 2'($urandom_range(0, 3)),
                                              $urandom, $urandom));
            end
            wait_until_idle();
        end

        if (results_due.size() != 0) begin
            $display("%0d results never arrived", results_due.size());
            mismatch_count += results_due.size();
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
